// ===== rtl/lsh_pkg.sv =====
// Shared types and constants for the link set-up handshake block.
package lsh_pkg;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;

	// Input request kinds carried on s_tuser
	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_BYTE  = 2'd1,
		REQ_TICK  = 2'd2
	} lsh_req_t;

	// Link phase, also the reported link status code
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_CONN = 2'd2,
		PH_FAIL = 2'd3
	} lsh_phase_t;

	// Reply recognizer states
	typedef enum logic [2:0] {
		FS_START = 3'd0,
		FS_FLAG  = 3'd1,
		FS_ADDR  = 3'd2,
		FS_CTRL  = 3'd3,
		FS_CHECK = 3'd4
	} lsh_fstate_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_TIMEOUT = 3'd0,
		CFG_MAX_RTX = 3'd1,
		CFG_ADDRESS = 3'd2,
		CFG_SET_CTL = 3'd3,
		CFG_UA_CTL  = 3'd4
	} lsh_cfg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [2:0]  max_retransmissions;
		logic [7:0]  address_byte;
		logic [7:0]  set_control;
		logic [7:0]  ua_control;
	} lsh_cfg_t;

	// Command from the front to the back: one frame or one status beat
	typedef struct packed {
		logic       is_frame;
		lsh_phase_t status;
	} lsh_cmd_t;

	// Frame beat positions
	localparam int          FRAME_BEATS = 5;
	localparam logic [2:0]  BEAT_FIRST  = 3'd0;
	localparam logic [2:0]  BEAT_ADDR   = 3'd1;
	localparam logic [2:0]  BEAT_CTRL   = 3'd2;
	localparam logic [2:0]  BEAT_CHECK  = 3'd3;
	localparam logic [2:0]  BEAT_LAST   = 3'd4;

endpackage

// ===== rtl/link_setup_handshake.sv =====
// Top level of the link set-up handshake (SET/UA) transmitter block.
//
// Requests arrive on the s_ stream: s_tuser selects start (0), received byte (1)
// or timer tick (2), and s_tdata carries the received byte. A start request,
// or a tick that expires the reply timeout while retries remain, yields a
// five-beat SET frame on the m_ stream: flag, address, SET control, check
// byte (address XOR control), flag, with m_tuser high on each beat and m_tlast
// on the closing flag. Every other request yields one status beat with m_tuser
// low, tx byte zero and m_tlast high. m_tdata carries the link status on each
// beat (0 idle, 1 waiting, 2 connected, 3 failed). The front end takes one
// request per cycle while the command queue has room; the beat generator
// drives one beat per cycle unless m_tready stalls it, so a frame request occupies
// the output for five beats and any other request for one. Sustained throughput
// is set by the output serializer; the queue absorbs short bursts. Configuration
// writes on cfg_we/cfg_index/cfg_wdata take effect at the next edge; indexes past
// the last register are dropped. Write configuration only while the block is idle.
module link_setup_handshake #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
	input  logic [1:0]                      s_tuser,   // [1:0] req_type
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [15:0]                     m_tdata,   // [7:0] tx_byte, [9:8] link_status
	output logic                            m_tlast,   // last
	output logic                            m_tuser,   // [0] tx_valid
	// configuration write port
	input  logic                            cfg_we,
	input  logic [lsh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lsh_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	lsh_pkg::lsh_cfg_t cfg_q;
	lsh_pkg::lsh_cmd_t push_cmd;
	lsh_pkg::lsh_cmd_t head_cmd;
	logic              accept;
	logic              push;
	logic              pop;
	logic              q_empty;
	logic              q_full;

	// Configuration registers; reset to the documented defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks       <= 16'd3;
			cfg_q.max_retransmissions <= 3'd3;
			cfg_q.address_byte        <= 8'h03;
			cfg_q.set_control         <= 8'h03;
			cfg_q.ua_control          <= 8'h07;
		end else if (cfg_we) begin
			case (cfg_index)
				lsh_pkg::CFG_TIMEOUT: cfg_q.timeout_ticks       <= cfg_wdata;
				lsh_pkg::CFG_MAX_RTX: cfg_q.max_retransmissions <= cfg_wdata[2:0];
				lsh_pkg::CFG_ADDRESS: cfg_q.address_byte        <= cfg_wdata[7:0];
				lsh_pkg::CFG_SET_CTL: cfg_q.set_control         <= cfg_wdata[7:0];
				lsh_pkg::CFG_UA_CTL:  cfg_q.ua_control          <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Take a request whenever the queue can hold its command
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	lsh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req_type (s_tuser),
		.rx_byte  (s_tdata),
		.cfg      (cfg_q),
		.push     (push),
		.cmd      (push_cmd)
	);

	lsh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	lsh_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== rtl/lsh_front.sv =====
// Front end: accepts requests, runs the link state and reply recognizer, issues commands.
module lsh_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         req_type,
	input  logic [7:0]         rx_byte,
	input  lsh_pkg::lsh_cfg_t  cfg,
	output logic               push,
	output lsh_pkg::lsh_cmd_t  cmd
);

	lsh_pkg::lsh_phase_t  phase_q, phase_n;
	lsh_pkg::lsh_fstate_t fs_q, fs_n;
	logic [3:0]           retry_q, retry_n;
	logic [15:0]          tick_q, tick_n;
	logic [15:0]          tick_inc;
	logic [3:0]           retry_inc;
	logic [7:0]           ua_check;

	assign tick_inc  = tick_q + 16'd1;
	assign retry_inc = retry_q + 4'd1;
	assign ua_check  = cfg.address_byte ^ cfg.ua_control;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lsh_pkg::PH_IDLE;
			fs_q    <= lsh_pkg::FS_START;
			retry_q <= '0;
			tick_q  <= '0;
		end else begin
			phase_q <= phase_n;
			fs_q    <= fs_n;
			retry_q <= retry_n;
			tick_q  <= tick_n;
		end
	end

	always_comb begin
		phase_n      = phase_q;
		fs_n         = fs_q;
		retry_n      = retry_q;
		tick_n       = tick_q;
		cmd.is_frame = 1'b0;
		if (accept) begin
			case (req_type)
				lsh_pkg::REQ_START: begin
					phase_n      = lsh_pkg::PH_WAIT;
					fs_n         = lsh_pkg::FS_START;
					retry_n      = '0;
					tick_n       = '0;
					cmd.is_frame = 1'b1;
				end
				lsh_pkg::REQ_BYTE: begin
					if (phase_q == lsh_pkg::PH_WAIT) begin
						case (fs_q)
							lsh_pkg::FS_START: begin
								if (rx_byte == lsh_pkg::FLAG_BYTE) fs_n = lsh_pkg::FS_FLAG;
							end
							lsh_pkg::FS_FLAG: begin
								if (rx_byte == cfg.address_byte) fs_n = lsh_pkg::FS_ADDR;
								else if (rx_byte == lsh_pkg::FLAG_BYTE) fs_n = lsh_pkg::FS_FLAG;
								else fs_n = lsh_pkg::FS_START;
							end
							lsh_pkg::FS_ADDR: begin
								if (rx_byte == cfg.ua_control) fs_n = lsh_pkg::FS_CTRL;
								else if (rx_byte == lsh_pkg::FLAG_BYTE) fs_n = lsh_pkg::FS_FLAG;
								else fs_n = lsh_pkg::FS_START;
							end
							lsh_pkg::FS_CTRL: begin
								if (rx_byte == ua_check) fs_n = lsh_pkg::FS_CHECK;
								else if (rx_byte == lsh_pkg::FLAG_BYTE) fs_n = lsh_pkg::FS_FLAG;
								else fs_n = lsh_pkg::FS_START;
							end
							lsh_pkg::FS_CHECK: begin
								if (rx_byte == lsh_pkg::FLAG_BYTE) begin
									phase_n = lsh_pkg::PH_CONN;
									tick_n  = '0;
								end
								fs_n = lsh_pkg::FS_START;
							end
							default: begin
								fs_n = lsh_pkg::FS_START;
							end
						endcase
					end
				end
				lsh_pkg::REQ_TICK: begin
					if (phase_q == lsh_pkg::PH_WAIT) begin
						if (tick_inc >= cfg.timeout_ticks || tick_inc == 16'd0) begin
							// timeout: restart the recognizer, resend or give up
							tick_n  = '0;
							retry_n = retry_inc;
							fs_n    = lsh_pkg::FS_START;
							if (retry_inc > {1'b0, cfg.max_retransmissions}) begin
								phase_n = lsh_pkg::PH_FAIL;
							end else begin
								cmd.is_frame = 1'b1;
							end
						end else begin
							tick_n = tick_inc;
						end
					end
				end
				default: begin
				end
			endcase
		end
		cmd.status = phase_n;
	end

	assign push = accept;

endmodule

// ===== rtl/lsh_queue.sv =====
// Short command queue between the front end and the beat generator.
module lsh_queue #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lsh_pkg::lsh_cmd_t push_cmd,
	input  logic              pop,
	output lsh_pkg::lsh_cmd_t head_cmd,
	output logic              empty,
	output logic              full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	lsh_pkg::lsh_cmd_t slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_FULL);
	assign head_cmd = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command queue read while empty");

endmodule

// ===== rtl/lsh_back.sv =====
// Beat generator: expands queued commands into frame bytes or one status beat.
module lsh_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lsh_pkg::lsh_cfg_t  cfg,
	input  lsh_pkg::lsh_cmd_t  head_cmd,
	input  logic               empty,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [15:0]        m_tdata,
	output logic               m_tlast,
	output logic               m_tuser
);

	logic                m_tvalid_q;
	logic [15:0]         m_tdata_q;
	logic                m_tlast_q;
	logic                m_tuser_q;
	logic                busy_q;
	logic [2:0]          beat_q;
	lsh_pkg::lsh_phase_t status_q;
	logic                advance;
	logic [7:0]          beat_byte;

	assign advance = !m_tvalid_q || m_tready;
	assign pop     = advance && !busy_q && !empty;

	always_comb begin
		case (beat_q)
			lsh_pkg::BEAT_ADDR:  beat_byte = cfg.address_byte;
			lsh_pkg::BEAT_CTRL:  beat_byte = cfg.set_control;
			lsh_pkg::BEAT_CHECK: beat_byte = cfg.address_byte ^ cfg.set_control;
			default:             beat_byte = lsh_pkg::FLAG_BYTE;
		endcase
	end

	// payload of the output register
	always_ff @(posedge clk) begin
		if (advance) begin
			if (busy_q) begin
				m_tdata_q <= {6'd0, status_q, beat_byte};
				m_tlast_q <= (beat_q == lsh_pkg::BEAT_LAST);
				m_tuser_q <= 1'b1;
			end else if (!empty) begin
				status_q <= head_cmd.status;
				if (head_cmd.is_frame) begin
					m_tdata_q <= {6'd0, head_cmd.status, lsh_pkg::FLAG_BYTE};
					m_tlast_q <= 1'b0;
					m_tuser_q <= 1'b1;
				end else begin
					m_tdata_q <= {6'd0, head_cmd.status, 8'd0};
					m_tlast_q <= 1'b1;
					m_tuser_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			busy_q     <= 1'b0;
			beat_q     <= lsh_pkg::BEAT_FIRST;
		end else if (advance) begin
			if (busy_q) begin
				m_tvalid_q <= 1'b1;
				busy_q     <= (beat_q != lsh_pkg::BEAT_LAST);
				beat_q     <= beat_q + 3'd1;
			end else if (!empty) begin
				m_tvalid_q <= 1'b1;
				busy_q     <= head_cmd.is_frame;
				beat_q     <= lsh_pkg::BEAT_ADDR;
			end else begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	a_busy_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> m_tvalid_q && !m_tlast_q && m_tuser_q)
		else $error("frame in progress without a pending frame beat");

	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> beat_q <= lsh_pkg::BEAT_LAST && beat_q != lsh_pkg::BEAT_FIRST)
		else $error("frame beat position out of range");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking testbench for the link set-up handshake block, with a built-in link predictor.
module testbench;
	import lsh_pkg::*;

	// Request kind the block must ignore
	localparam logic [1:0] REQ_UNUSED   = 2'd3;
	// Highest index the configuration port can address; indexes past CFG_UA_CTL are spare
	localparam logic [2:0] CFG_IDX_LAST = 3'd7;

	// One result beat as the block presents it on the m_ stream
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       last;
		lsh_phase_t status;
	} tx_beat_t;

	// Link predictor plus the queue of result beats it still owes
	class link_setup_scoreboard;
		logic [15:0] timeout_ticks;
		logic [2:0]  max_rtx;
		logic [7:0]  address;
		logic [7:0]  set_ctl;
		logic [7:0]  ua_ctl;

		lsh_phase_t  phase;
		lsh_fstate_t fstate;
		logic [3:0]  retries;
		logic [15:0] ticks;

		tx_beat_t    expected_beats[$];
		int          errors;
		int          requests;
		int          frames;
		int          resends;
		int          status_beats;
		int          connects;
		int          fails;
		int          beats_checked;

		function new();
			timeout_ticks = 16'd3;
			max_rtx       = 3'd3;
			address       = 8'h03;
			set_ctl       = 8'h03;
			ua_ctl        = 8'h07;
			phase         = PH_IDLE;
			fstate        = FS_START;
			retries       = 4'd0;
			ticks         = 16'd0;
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] value);
			case (idx)
				CFG_TIMEOUT: timeout_ticks = value;
				CFG_MAX_RTX: max_rtx = value[2:0];
				CFG_ADDRESS: address = value[7:0];
				CFG_SET_CTL: set_ctl = value[7:0];
				CFG_UA_CTL:  ua_ctl = value[7:0];
				default: ;
			endcase
		endfunction

		function void push_frame();
			frames++;
			expected_beats.push_back(tx_beat_t'{1'b1, FLAG_BYTE, 1'b0, phase});
			expected_beats.push_back(tx_beat_t'{1'b1, address, 1'b0, phase});
			expected_beats.push_back(tx_beat_t'{1'b1, set_ctl, 1'b0, phase});
			expected_beats.push_back(tx_beat_t'{1'b1, address ^ set_ctl, 1'b0, phase});
			expected_beats.push_back(tx_beat_t'{1'b1, FLAG_BYTE, 1'b1, phase});
		endfunction

		function void push_status();
			status_beats++;
			expected_beats.push_back(tx_beat_t'{1'b0, 8'h00, 1'b1, phase});
		endfunction

		// Advance the predictor by one accepted request beat
		function void note_request(logic [1:0] kind, logic [7:0] rx);
			requests++;
			case (kind)
				REQ_START: begin
					phase   = PH_WAIT;
					fstate  = FS_START;
					retries = 4'd0;
					ticks   = 16'd0;
					push_frame();
				end
				REQ_BYTE: begin
					if (phase == PH_WAIT) begin
						// Expected byte wins over the flag in every state
						case (fstate)
							FS_START: if (rx == FLAG_BYTE) fstate = FS_FLAG;
							FS_FLAG: begin
								if (rx == address) fstate = FS_ADDR;
								else if (rx == FLAG_BYTE) fstate = FS_FLAG;
								else fstate = FS_START;
							end
							FS_ADDR: begin
								if (rx == ua_ctl) fstate = FS_CTRL;
								else if (rx == FLAG_BYTE) fstate = FS_FLAG;
								else fstate = FS_START;
							end
							FS_CTRL: begin
								if (rx == (address ^ ua_ctl)) fstate = FS_CHECK;
								else if (rx == FLAG_BYTE) fstate = FS_FLAG;
								else fstate = FS_START;
							end
							FS_CHECK: begin
								if (rx == FLAG_BYTE) begin
									phase = PH_CONN;
									ticks = 16'd0;
									connects++;
								end
								fstate = FS_START;
							end
							default: fstate = FS_START;
						endcase
					end
					push_status();
				end
				REQ_TICK: begin
					if (phase == PH_WAIT) begin
						ticks = ticks + 16'd1;
						// A zero timeout expires on the first tick
						if (ticks >= timeout_ticks || ticks == 16'd0) begin
							ticks   = 16'd0;
							retries = retries + 4'd1;
							fstate  = FS_START;
							if (retries > {1'b0, max_rtx}) begin
								phase = PH_FAIL;
								fails++;
								push_status();
							end else begin
								resends++;
								push_frame();
							end
						end else begin
							push_status();
						end
					end else begin
						push_status();
					end
				end
				default: push_status();
			endcase
		endfunction

		function void report(string field, int unsigned want_v, int unsigned got_v);
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
		endfunction

		// Compare one result beat with the oldest expectation
		function void check_beat(tx_beat_t got);
			tx_beat_t want;
			beats_checked++;
			if (expected_beats.size() == 0) begin
				errors++;
				$display("%0t: beat with nothing expected, actual valid=%0b byte=%02h last=%0b status=%0d",
					$time, got.tx_valid, got.tx_byte, got.last, got.status);
				return;
			end
			want = expected_beats.pop_front();
			if (got.tx_valid !== want.tx_valid) report("tx_valid", want.tx_valid, got.tx_valid);
			if (got.tx_byte !== want.tx_byte) report("tx_byte", want.tx_byte, got.tx_byte);
			if (got.last !== want.last) report("last", want.last, got.last);
			if (got.status !== want.status) report("link_status", want.status, got.status);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;   // [7:0] rx_byte
	logic [1:0]            s_tuser;   // [1:0] req_type
	logic                  m_tvalid;
	logic                  m_tready;
	logic [15:0]           m_tdata;   // [7:0] tx_byte, [9:8] link_status
	logic                  m_tlast;   // last
	logic                  m_tuser;   // [0] tx_valid
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	link_setup_scoreboard sb = new();

	int src_idle_pct;
	int dst_idle_pct;
	int accepted_count;

	link_setup_handshake u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// Sample both streams at the rising edge. Note the request beat before checking
	// the result beat so a same-cycle result can never race its own request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_request(s_tuser, s_tdata);
				accepted_count++;
			end
			if (m_tvalid && m_tready)
				sb.check_beat(tx_beat_t'{m_tuser, m_tdata[7:0], m_tlast, lsh_phase_t'(m_tdata[9:8])});
		end
	end

	// Receiver: stall at random on each falling edge
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
	end

	// Present one request beat at a falling edge and hold it until the monitor
	// has taken it. Leave tvalid high so the next call can go back to back.
	task automatic send_request(input logic [1:0] kind, input logic [7:0] rx);
		int target;
		target = accepted_count + 1;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tuser  <= kind;
		s_tdata  <= rx;
		s_tvalid <= 1'b1;
		wait (accepted_count == target);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_request(REQ_BYTE, b);
	endtask

	// The data field is unused for ticks; fill it with noise anyway
	task automatic send_tick();
		send_request(REQ_TICK, 8'($urandom));
	endtask

	// Drop tvalid, then hold until every owed beat has come out plus some slack
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Write one register; fill the bits above its width with noise
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] value, input int width);
		logic [15:0] keep;
		keep = (width >= 16) ? 16'hFFFF : ((16'd1 << width) - 16'd1);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= (16'($urandom) & ~keep) | (value & keep);
		@(posedge clk);
		sb.write_reg(idx, cfg_wdata);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [15:0] tmo, input logic [2:0] rtx,
			input logic [7:0] addr, input logic [7:0] setc, input logic [7:0] uac);
		write_reg(CFG_TIMEOUT, tmo, 16);
		write_reg(CFG_MAX_RTX, rtx, 3);
		write_reg(CFG_ADDRESS, addr, 8);
		write_reg(CFG_SET_CTL, setc, 8);
		write_reg(CFG_UA_CTL, uac, 8);
	endtask

	// flavor 1: low corner, 2: high corner, otherwise random with a bias
	// toward short timeouts and byte values that collide with the flag
	task automatic configure_random(input int flavor);
		logic [15:0] tmo;
		logic [7:0]  addr;
		logic [7:0]  uac;
		case (flavor)
			1: configure(16'd1, 3'd0, 8'h00, 8'h00, 8'h00);
			2: configure(16'hFFFF, 3'd7, 8'hFF, 8'hFF, 8'hFF);
			default: begin
				tmo  = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(7, 65535))
					: 16'($urandom_range(1, 6));
				addr = ($urandom_range(0, 4) == 0) ? FLAG_BYTE : 8'($urandom);
				case ($urandom_range(0, 9))
					0, 1: uac = FLAG_BYTE;
					2: uac = addr;
					default: uac = 8'($urandom);
				endcase
				configure(tmo, 3'($urandom_range(0, 7)), addr, 8'($urandom), uac);
			end
		endcase
	endtask

	// Send a UA reply built from the current settings; now and then corrupt
	// one byte, lead with a stray flag, or slip a tick in between
	task automatic send_reply();
		logic [7:0] seq [5];
		int         pos;
		int         i;
		seq[0] = FLAG_BYTE;
		seq[1] = sb.address;
		seq[2] = sb.ua_ctl;
		seq[3] = sb.address ^ sb.ua_ctl;
		seq[4] = FLAG_BYTE;
		if ($urandom_range(0, 3) == 0) begin
			pos      = $urandom_range(0, 4);
			seq[pos] = $urandom_range(0, 1) ? FLAG_BYTE : 8'($urandom);
		end
		if ($urandom_range(0, 6) == 0)
			send_byte(FLAG_BYTE);
		for (i = 0; i < 5; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_tick();
			send_byte(seq[i]);
		end
	endtask

	// Random traffic until quota request beats have been accepted
	task automatic run_traffic(input int quota);
		int first;
		int r;
		first = accepted_count;
		while (accepted_count - first < quota) begin
			if (sb.phase != PH_WAIT && $urandom_range(0, 9) < 7) begin
				// Link is idle, up or down: mostly restart so the recognizer gets exercised
				send_request(REQ_START, 8'($urandom));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5) send_request(REQ_START, 8'($urandom));
				else if (r < 45) send_reply();
				else if (r < 65) repeat ($urandom_range(1, 4)) send_tick();
				else if (r < 85) send_byte($urandom_range(0, 1) ? FLAG_BYTE : 8'($urandom));
				else if (r < 90) send_request(REQ_UNUSED, 8'($urandom));
				else if (r < 98) repeat ($urandom_range(4, 16)) send_tick();
				else wait_drained();
			end
		end
	endtask

	initial begin
		int regime;
		int ph;
		int spare;

		// Drive every input to a known value before the first edge
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = 8'h00;
		s_tuser        = REQ_START;
		m_tready       = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_TIMEOUT;
		cfg_wdata      = 16'h0000;
		accepted_count = 0;
		src_idle_pct   = 22;
		dst_idle_pct   = 47;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at reset settings: timeout 3, three resends, address 03,
		// SET control 03, UA control 07, so the reply check byte is 04.
		// Beats while idle and an unknown request are ignored.
		send_tick();
		send_byte(8'hFF);
		send_request(REQ_UNUSED, 8'hAA);
		send_request(REQ_START, 8'h00);
		// Stray flag after a flag, flag in place of the control byte, then a good
		// reply broken by a non-flag byte in the check-valid state
		send_byte(FLAG_BYTE);
		send_byte(FLAG_BYTE);
		send_byte(8'h03);
		send_byte(FLAG_BYTE);
		send_byte(8'h03);
		send_byte(8'h07);
		send_byte(8'h04);
		send_byte(8'h00);
		// Third tick expires the timeout and resends the frame
		repeat (3) send_tick();
		// Full reply: link goes up
		send_byte(FLAG_BYTE);
		send_byte(8'h03);
		send_byte(8'h07);
		send_byte(8'h04);
		send_byte(FLAG_BYTE);
		// Start from connected, then start again while still waiting
		send_request(REQ_START, 8'hFF);
		send_request(REQ_START, 8'h5A);
		wait_drained();

		// Zero timeout, no resends, and address and UA control both equal to the flag.
		// Writes to spare indexes must leave the settings alone.
		configure(16'd0, 3'd0, FLAG_BYTE, 8'hFF, FLAG_BYTE);
		for (spare = int'(CFG_UA_CTL) + 1; spare <= int'(CFG_IDX_LAST); spare++)
			write_reg(3'(spare), 16'($urandom), 16);
		send_request(REQ_START, 8'h00);
		send_tick();
		send_request(REQ_START, 8'h00);
		send_byte(FLAG_BYTE);
		send_byte(FLAG_BYTE);
		send_byte(FLAG_BYTE);
		send_byte(8'h00);
		send_byte(FLAG_BYTE);

		// Random part: three idle patterns, four settings each; the first two start with a corner
		for (regime = 0; regime < 3; regime++) begin
			src_idle_pct = (regime == 0) ? 22 : (regime == 1) ? 47 : 0;
			dst_idle_pct = (regime == 0) ? 47 : (regime == 1) ? 22 : 0;
			for (ph = 0; ph < 4; ph++) begin
				wait_drained();
				configure_random((ph == 0) ? regime + 1 : 0);
				run_traffic(38);
			end
		end

		wait_drained();

		$display("Run covered %0d requests: %0d SET frames including %0d resends, %0d status beats.",
			sb.requests, sb.frames, sb.resends, sb.status_beats);
		$display("Link came up %0d times and failed %0d times; %0d result beats checked.",
			sb.connects, sb.fails, sb.beats_checked);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
